// ===== src/vnf_pkg.sv =====
// ----------------------------------------------------------------------------
// vnf_pkg: shared types and constants for the fractal value noise core
// Holds the hash constants, fixed-point widths, the top-level state type and
// the step codes of the per-octave sequencer.
// ----------------------------------------------------------------------------
package vnf_pkg;

  // Fixed-point formats.
  localparam int COORD_W  = 32;
  localparam int SCALED_W = 48;
  localparam int FRAC_W   = 16;
  localparam int VALUE_W  = 24;
  localparam int CFG_W    = 4;
  localparam int WEIGHT_W = 17;
  localparam int MAC_W    = 48;

  localparam logic [CFG_W-1:0]    CFG_RESET  = 4'd4;
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = 24'hFF_FFFF;
  localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h1_0000;
  localparam logic [17:0]         THREE_Q16  = 18'd196608;

  // Lattice hash constants.
  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S = 32'd2147483647;
  localparam logic [31:0] HASH_MIX   = 32'd1274126177;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OCT,
    ST_DIV,
    ST_DONE
  } core_state_t;

  // One multiplier operation per step of an octave.
  typedef enum logic [4:0] {
    STEP_PX,
    STEP_PZ,
    STEP_PS,
    STEP_FX2,
    STEP_WX,
    STEP_FZ2,
    STEP_WZ,
    STEP_H00,
    STEP_H10,
    STEP_H01,
    STEP_H11,
    STEP_A0,
    STEP_A1,
    STEP_B0,
    STEP_B1,
    STEP_C0,
    STEP_C1
  } step_t;

endpackage

// ===== src/vnf_octave_engine.sv =====
// ----------------------------------------------------------------------------
// vnf_octave_engine: per-octave noise evaluation on one shared multiplier
// A small sequencer walks seventeen steps per octave through a single
// 32x32 multiply-accumulate unit and folds each octave into a weighted sum.
// ----------------------------------------------------------------------------
module vnf_octave_engine #(
  parameter int MAX_OCTAVES = 8,
  localparam int OCT_W = $clog2(MAX_OCTAVES + 1),
  localparam int ACC_W = vnf_pkg::VALUE_W + MAX_OCTAVES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [vnf_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [vnf_pkg::COORD_W-1:0]  coord_z,
  input  logic [31:0]                         noise_seed,
  input  logic [OCT_W-1:0]                    octaves,
  output logic                                done,
  output logic [ACC_W-1:0]                    acc
);
  import vnf_pkg::*;

  // Sequencer state.
  logic             busy;
  step_t            step;
  logic [OCT_W-1:0] oct;
  logic [OCT_W-1:0] n_oct;

  // Per-octave working registers.
  logic [SCALED_W-1:0] sx;
  logic [SCALED_W-1:0] sz;
  logic [31:0]         seed_oct;
  logic [31:0]         pxs;
  logic [31:0]         pz;
  logic [FRAC_W-1:0]   f2;
  logic [WEIGHT_W-1:0] wx;
  logic [WEIGHT_W-1:0] wz;
  logic [VALUE_W-1:0]  v00;
  logic [VALUE_W-1:0]  v10;
  logic [VALUE_W-1:0]  v01;
  logic [VALUE_W-1:0]  v11;
  logic [VALUE_W-1:0]  ba;
  logic [VALUE_W-1:0]  bb;
  logic [MAC_W-1:0]    part;

  // Shared multiply-accumulate unit.
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [MAC_W-1:0]    mul_add;
  logic [63:0]         prod;
  logic [MAC_W-1:0]    mac;
  logic [31:0]         base;
  logic [31:0]         mix_in;
  logic [31:0]         mix_out;
  logic [VALUE_W-1:0]  hash_val;
  logic [VALUE_W-1:0]  blend_val;
  logic [FRAC_W-1:0]   fx;
  logic [FRAC_W-1:0]   fz;
  logic [WEIGHT_W-1:0] wx_inv;
  logic [WEIGHT_W-1:0] wz_inv;

  assign fx     = sx[FRAC_W-1:0];
  assign fz     = sz[FRAC_W-1:0];
  assign wx_inv = ONE_Q16 - wx;
  assign wz_inv = ONE_Q16 - wz;

  // Operand selection for the current step. The +1 lattice corners reuse the
  // base products: (x0+1)*MX equals x0*MX + MX modulo 2^32.
  always_comb begin
    base = pxs + pz
         + (((step == STEP_H10) || (step == STEP_H11)) ? HASH_MUL_X : 32'd0)
         + (((step == STEP_H01) || (step == STEP_H11)) ? HASH_MUL_Z : 32'd0);
    mix_in  = base ^ (base >> 13);
    mul_a   = '0;
    mul_b   = '0;
    mul_add = '0;
    case (step)
      STEP_PX: begin
        mul_a = sx[SCALED_W-1:FRAC_W];
        mul_b = HASH_MUL_X;
      end
      STEP_PZ: begin
        mul_a = sz[SCALED_W-1:FRAC_W];
        mul_b = HASH_MUL_Z;
      end
      STEP_PS: begin
        mul_a   = seed_oct;
        mul_b   = HASH_MUL_S;
        mul_add = MAC_W'(pxs);
      end
      STEP_FX2: begin
        mul_a = 32'(fx);
        mul_b = 32'(fx);
      end
      STEP_WX: begin
        mul_a = 32'(f2);
        mul_b = 32'(THREE_Q16 - {1'b0, fx, 1'b0});
      end
      STEP_FZ2: begin
        mul_a = 32'(fz);
        mul_b = 32'(fz);
      end
      STEP_WZ: begin
        mul_a = 32'(f2);
        mul_b = 32'(THREE_Q16 - {1'b0, fz, 1'b0});
      end
      STEP_H00, STEP_H10, STEP_H01, STEP_H11: begin
        mul_a = mix_in;
        mul_b = HASH_MIX;
      end
      STEP_A0: begin
        mul_a = 32'(v00);
        mul_b = 32'(wx_inv);
      end
      STEP_A1: begin
        mul_a   = 32'(v10);
        mul_b   = 32'(wx);
        mul_add = part;
      end
      STEP_B0: begin
        mul_a = 32'(v01);
        mul_b = 32'(wx_inv);
      end
      STEP_B1: begin
        mul_a   = 32'(v11);
        mul_b   = 32'(wx);
        mul_add = part;
      end
      STEP_C0: begin
        mul_a = 32'(ba);
        mul_b = 32'(wz_inv);
      end
      STEP_C1: begin
        mul_a   = 32'(bb);
        mul_b   = 32'(wz);
        mul_add = part;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign mac       = prod[MAC_W-1:0] + mul_add;
  assign mix_out   = mac[31:0] ^ (mac[31:0] >> 16);
  assign hash_val  = mix_out[VALUE_W-1:0];
  assign blend_val = mac[FRAC_W+VALUE_W-1:FRAC_W];

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_PX;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= STEP_PX;
        oct      <= '0;
        n_oct    <= octaves;
        acc      <= '0;
        sx       <= {{(SCALED_W-COORD_W){coord_x[COORD_W-1]}}, coord_x};
        sz       <= {{(SCALED_W-COORD_W){coord_z[COORD_W-1]}}, coord_z};
        seed_oct <= noise_seed;
      end else if (busy) begin
        case (step)
          STEP_PX:  pxs <= mac[31:0];
          STEP_PZ:  pz  <= mac[31:0];
          STEP_PS:  pxs <= mac[31:0];
          STEP_FX2: f2  <= mac[2*FRAC_W-1:FRAC_W];
          STEP_WX:  wx  <= mac[FRAC_W+WEIGHT_W-1:FRAC_W];
          STEP_FZ2: f2  <= mac[2*FRAC_W-1:FRAC_W];
          STEP_WZ:  wz  <= mac[FRAC_W+WEIGHT_W-1:FRAC_W];
          STEP_H00: v00 <= hash_val;
          STEP_H10: v10 <= hash_val;
          STEP_H01: v01 <= hash_val;
          STEP_H11: v11 <= hash_val;
          STEP_A0:  part <= mac;
          STEP_A1:  ba  <= blend_val;
          STEP_B0:  part <= mac;
          STEP_B1:  bb  <= blend_val;
          STEP_C0:  part <= mac;
          STEP_C1:  acc <= {acc[ACC_W-2:0], 1'b0} + ACC_W'(blend_val);
          default:  part <= mac;
        endcase

        // Advance the step, or close the octave and move to the next one.
        if (step == STEP_C1) begin
          step <= STEP_PX;
          if (oct + 1'b1 == n_oct) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            oct      <= oct + 1'b1;
            sx       <= {sx[SCALED_W-2:0], 1'b0};
            sz       <= {sz[SCALED_W-2:0], 1'b0};
            seed_oct <= seed_oct + 32'd1;
          end
        end else begin
          step <= step_t'(step + 5'd1);
        end
      end
    end
  end

endmodule

// ===== src/vnf_divider.sv =====
// ----------------------------------------------------------------------------
// vnf_divider: iterative restoring divider
// Produces one quotient bit per cycle by shift and conditional subtract.
// ----------------------------------------------------------------------------
module vnf_divider #(
  parameter int ACC_W = 32,
  parameter int DIV_W = 8,
  localparam int CNT_W = $clog2(ACC_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [ACC_W-1:0] quotient
);
  import vnf_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             q_bit;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh  = {rem, quotient[ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign q_bit   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= CNT_W'(ACC_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quotient <= {quotient[ACC_W-2:0], q_bit};
        count    <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/value_noise_fbm_2d_core.sv =====
// ----------------------------------------------------------------------------
// value_noise_fbm_2d_core: fractal two-dimensional value noise
// Evaluates hashed lattice value noise over several octaves in fixed point
// and returns the normalized sum in unsigned Q0.24.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one point (coord_x,
//   coord_z in signed Q16.16) and a seed per transfer. The output channel
//   (out_valid / out_stall) carries one noise_value per input transfer, in
//   order. The octave count is written through cfg_we / cfg_wdata while the
//   core is idle; values above MAX_OCTAVES act as MAX_OCTAVES.
//   With n = 0 the result is 0 and no octave or division runs. Each
//   octave takes seventeen passes through the single shared multiplier, and
//   the final normalization is a restoring divider giving one bit per cycle.
//   One item is in work at a time: in_stall is high from the input transfer
//   until the result moves into the output register. A result held by a
//   stalled receiver does not block the next input transfer; the following
//   result waits in the core until the output register frees up.
//   Reset (rst, synchronous) empties the core and the output register and
//   sets the octave count to 4.
// ----------------------------------------------------------------------------
module value_noise_fbm_2d_core #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vnf_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vnf_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [vnf_pkg::COORD_W-1:0]  coord_z,
  input  logic [31:0]                         noise_seed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vnf_pkg::VALUE_W-1:0]         noise_value
);
  import vnf_pkg::*;

  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W  = VALUE_W + MAX_OCTAVES;
  localparam int DIV_W  = MAX_OCTAVES;
  localparam int DIV_W1 = DIV_W + 1;

  // Configuration and control registers.
  logic [CFG_W-1:0]   octave_count;
  core_state_t        state;
  core_state_t        state_next;
  logic [OCT_W-1:0]   n_oct;
  logic [VALUE_W-1:0] result;
  logic [VALUE_W-1:0] result_next;

  logic               in_accept;
  logic               out_load;
  logic [OCT_W-1:0]   n_eff;
  logic               eng_start;
  logic               eng_done;
  logic [ACC_W-1:0]   eng_acc;
  logic               div_start;
  logic               div_done;
  logic [ACC_W-1:0]   div_quo;
  logic [DIV_W1-1:0]  pow;
  logic [DIV_W-1:0]   divisor;

  // Octave count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= CFG_RESET;
    end else if (cfg_we) begin
      octave_count <= cfg_wdata;
    end
  end

  // Saturate the configured count to what the hardware supports.
  assign n_eff = ({1'b0, octave_count} > (CFG_W+1)'(MAX_OCTAVES)) ?
                 OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count);

  // Weight total 2^n - 1 for the normalizing division.
  assign pow     = DIV_W1'(1) << n_oct;
  assign divisor = DIV_W'(pow - DIV_W1'(1));

  vnf_octave_engine #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (eng_start),
    .coord_x    (coord_x),
    .coord_z    (coord_z),
    .noise_seed (noise_seed),
    .octaves    (n_eff),
    .done       (eng_done),
    .acc        (eng_acc)
  );

  vnf_divider #(
    .ACC_W (ACC_W),
    .DIV_W (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (eng_acc),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Control state register and result holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    result <= result_next;
    if (in_accept) begin
      n_oct <= n_eff;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next  = state;
    result_next = result;
    in_stall    = 1'b1;
    eng_start   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    in_accept   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        in_accept = in_valid;
        if (in_valid) begin
          if (n_eff == '0) begin
            result_next = '0;
            state_next  = ST_DONE;
          end else begin
            eng_start  = 1'b1;
            state_next = ST_OCT;
          end
        end
      end
      ST_OCT: begin
        if (eng_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          result_next = (div_quo > ACC_W'(VALUE_MAX)) ? VALUE_MAX : div_quo[VALUE_W-1:0];
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: a new result loads when the previous one has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      noise_value <= result;
    end
  end

endmodule

// ===== tb/tb_value_noise_fbm_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_fbm_2d_core: self-checking bench for the fractal noise core
// Feeds points and seeds through the input channel under several octave
// counts and checks every noise value against a bit-exact fixed-point
// predictor kept in the bench. Both channels see random gaps and stalls,
// and two long output hold-offs fill the core so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_value_noise_fbm_2d_core;

  localparam int          HALF_PERIOD   = 5;
  localparam int          RESET_CYCLES  = 6;
  localparam int          PHASE_ITEMS   = 100;
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          PRESSURE_HOLD = 600;
  localparam int          DRAIN_CYCLES  = 250;
  localparam int unsigned OCTAVE_CAP    = 8;

  // Hash and fixed-point constants of the noise function.
  localparam logic [31:0] K_X    = 32'd374761393;
  localparam logic [31:0] K_Z    = 32'd668265263;
  localparam logic [31:0] K_S    = 32'd2147483647;
  localparam logic [31:0] K_MIX  = 32'd1274126177;
  localparam logic [63:0] UNIT   = 64'd65536;

  typedef struct {
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] seed;
  } noise_point_t;

  typedef struct {
    noise_point_t pt;
    logic [23:0]  value;
  } noise_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_we    = 1'b0;
  logic [vnf_pkg::CFG_W-1:0]           cfg_wdata = '0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic signed [vnf_pkg::COORD_W-1:0]  coord_x   = '0;
  logic signed [vnf_pkg::COORD_W-1:0]  coord_z   = '0;
  logic [31:0]                         noise_seed = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [vnf_pkg::VALUE_W-1:0]         noise_value;

  noise_point_t  points_to_send[$];
  noise_result_t noise_expected[$];

  logic [3:0]  octave_setting = vnf_pkg::CFG_RESET;
  logic        pacing_on      = 1'b1;
  int          error_count    = 0;
  int          results_seen   = 0;
  int          send_gap       = 0;
  int          stall_left     = 0;
  int          quiet_cycles   = 0;

  value_noise_fbm_2d_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coord_x     (coord_x),
    .coord_z     (coord_z),
    .noise_seed  (noise_seed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
  );

  always #HALF_PERIOD clk = ~clk;

  // ------------------------------------------------------------------------
  // Fixed-point noise predictor
  // ------------------------------------------------------------------------

  // Lattice corner hash into a Q0.24 value.
  function automatic logic [23:0] lattice_hash(logic [31:0] cx, logic [31:0] cz,
                                               logic [31:0] s);
    logic [31:0] h;
    h = cx * K_X + cz * K_Z + s * K_S;
    h = (h ^ (h >> 13)) * K_MIX;
    h = h ^ (h >> 16);
    return h[23:0];
  endfunction

  // Smoothstep weight of a Q0.16 fraction.
  function automatic logic [63:0] smooth_weight(logic [15:0] f);
    logic [63:0] f2;
    logic [63:0] t;
    f2 = (64'(f) * 64'(f)) >> 16;
    t  = 3 * UNIT - 2 * 64'(f);
    return (f2 * t) >> 16;
  endfunction

  function automatic logic [63:0] mix_values(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] w);
    return (a * (UNIT - w) + b * w) >> 16;
  endfunction

  function automatic logic [23:0] fbm_noise(noise_point_t pt, logic [3:0] octs);
    logic [63:0] bx;
    logic [63:0] bz;
    logic [63:0] sx;
    logic [63:0] sz;
    logic [63:0] wx;
    logic [63:0] wz;
    logic [63:0] top;
    logic [63:0] bottom;
    logic [63:0] acc;
    logic [63:0] quot;
    logic [31:0] x0;
    logic [31:0] z0;
    logic [31:0] s;
    int unsigned n;
    bx  = {{32{pt.x[31]}}, pt.x};
    bz  = {{32{pt.z[31]}}, pt.z};
    n   = (octs > OCTAVE_CAP) ? OCTAVE_CAP : octs;
    acc = '0;
    if (n == 0) return '0;
    for (int unsigned i = 0; i < n; i++) begin
      sx     = bx << i;
      sz     = bz << i;
      x0     = sx[47:16];
      z0     = sz[47:16];
      s      = pt.seed + i;
      wx     = smooth_weight(sx[15:0]);
      wz     = smooth_weight(sz[15:0]);
      top    = mix_values(lattice_hash(x0, z0, s), lattice_hash(x0 + 1, z0, s), wx);
      bottom = mix_values(lattice_hash(x0, z0 + 1, s), lattice_hash(x0 + 1, z0 + 1, s), wx);
      acc    = acc + (mix_values(top, bottom, wz) << (n - 1 - i));
    end
    quot = acc / ((64'd1 << n) - 1);
    return (quot > 64'h00FF_FFFF) ? 24'hFF_FFFF : quot[23:0];
  endfunction

  // ------------------------------------------------------------------------
  // Random shaping
  // ------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    else if (r < 90) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // Coordinates cluster at the origin, the range ends and the cell edges.
  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    case ($urandom_range(0, 4))
      0: c = $urandom();
      1: begin
        c = $urandom_range(0, 32'h0003_FFFF);
        if ($urandom_range(0, 1) == 1) c = -c;
      end
      2: c = {($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
      3: c = {16'($urandom()), ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000};
      default: c = $urandom();
    endcase
    return c;
  endfunction

  function automatic noise_point_t random_point();
    noise_point_t pt;
    pt.x    = pick_coord();
    pt.z    = pick_coord();
    pt.seed = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF8 + $urandom_range(0, 7)
                                           : $urandom();
    return pt;
  endfunction

  // ------------------------------------------------------------------------
  // Input driver
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    noise_point_t  pt;
    noise_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // Predict the result of the point that transfers at this edge.
      if (in_valid && !in_stall) begin
        res.pt.x    = coord_x;
        res.pt.z    = coord_z;
        res.pt.seed = noise_seed;
        res.value   = fbm_noise(res.pt, octave_setting);
        noise_expected = {noise_expected, res};
      end
      // A held point stays put; otherwise offer the next one after any gap.
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (points_to_send.size() > 0) begin
          pt = points_to_send.pop_front();
          coord_x    <= pt.x;
          coord_z    <= pt.z;
          noise_seed <= pt.seed;
          in_valid   <= 1'b1;
          if (pacing_on && $urandom_range(0, 2) == 0) send_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Output monitor and checker
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    noise_result_t res;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected noise_value transfer: expected none, got %h",
                   $time, noise_value);
          error_count++;
        end else begin
          res = noise_expected.pop_front();
          if (noise_value !== res.value) begin
            $display("%0t: noise_value mismatch (x=%h z=%h seed=%h): expected %h, got %h",
                     $time, res.pt.x, res.pt.z, res.pt.seed, res.value, noise_value);
            error_count++;
          end
        end
        // Long hold-offs so that the core backs up into its input.
        if (results_seen == 60 || results_seen == 900) stall_left = PRESSURE_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pacing_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Watchdog: too long without any transfer ends the run.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus sequence
  // ------------------------------------------------------------------------
  task automatic queue_point(logic [31:0] x, logic [31:0] z, logic [31:0] seed);
    noise_point_t pt;
    pt.x    = x;
    pt.z    = z;
    pt.seed = seed;
    points_to_send = {points_to_send, pt};
  endtask

  // Wait until every point is sent and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (points_to_send.size() != 0 || in_valid || noise_expected.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_octaves(logic [3:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    octave_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0] settings[14];
    settings = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd2, 4'd9, 4'd3,
                 4'd5, 4'd6, 4'd7, 4'd12, 4'd4, 4'd8, 4'd1};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed points under the octave count left by reset.
    @(negedge clk);
    queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFF9);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h1234_5678);
    queue_point(32'h0000_8000, 32'h0001_0000, 32'h8000_0000);
    queue_point(32'h7FFF_0000, 32'h8000_FFFF, 32'h7FFF_FFFF);
    queue_point(32'hFFFF_0000, 32'h0000_FFFF, 32'hDEAD_BEEF);
    queue_point(32'h0000_0001, 32'h8000_0001, 32'h0000_0000);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE);
    wait_drained();

    // Random phases, each under its own octave count; some run without gaps.
    foreach (settings[p]) begin
      write_octaves(settings[p]);
      @(negedge clk);
      pacing_on = (p % 3 != 1);
      if (p < 4) begin
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0000);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) points_to_send = {points_to_send, random_point()};
      wait_drained();
    end

    // Catch any stray output before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
